// ===== sv/ofe_pkg.sv =====
// shared types and constants of the ofs file extractor
package ofe_pkg;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] sector_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [2:0]  valid_bytes;
      logic        block_last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_WORD,
      CMD_FAIL,
      CMD_NONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type cmd;
      logic [31:0]  word;
   } cmd_type;

   localparam logic [1:0] OPC_START = 2'd0;
   localparam logic [1:0] OPC_WORD  = 2'd1;
   localparam logic [1:0] OPC_FAIL  = 2'd2;

   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [31:0] STATUS_FAIL = 32'd0;
   localparam logic [31:0] STATUS_OK   = 32'd1;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_A   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_B   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_C   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME_D   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXP_SIZE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY = 3'd5;

   localparam logic [31:0] ROOT_SECTOR   = 32'd880;
   localparam logic [31:0] T_HEADER      = 32'd2;
   localparam logic [31:0] T_LIST        = 32'd16;
   localparam logic [31:0] T_DATA        = 32'd8;
   localparam logic [31:0] ST_ROOT       = 32'd1;
   localparam logic [31:0] ST_FILE       = 32'hfffffffd;
   localparam logic [31:0] DATA_MAX      = 32'd488;
   localparam logic [10:0] HASH_MULT     = 11'd13;
   localparam logic [7:0]  CHAR_COLON    = 8'h3a;
   localparam logic [7:0]  CHAR_SLASH    = 8'h2f;
   localparam logic [7:0]  CHAR_LOW      = 8'd32;
   localparam logic [7:0]  CHAR_HIGH     = 8'd126;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

endpackage

// ===== sv/ofe_front.sv =====
// front: input queue that accepts transfers and classifies the opcode
module ofe_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ofe_pkg::req_type req_payload,
   output logic            q_valid,
   output ofe_pkg::cmd_type q_cmd,
   input  logic            q_pop
);

   ofe_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   ofe_pkg::cmd_type entry;

   always_comb begin
      entry.word = req_payload.sector_word;
      unique case (req_payload.opcode)
         ofe_pkg::OPC_START: entry.cmd = ofe_pkg::CMD_START;
         ofe_pkg::OPC_WORD:  entry.cmd = ofe_pkg::CMD_WORD;
         ofe_pkg::OPC_FAIL:  entry.cmd = ofe_pkg::CMD_FAIL;
         default:            entry.cmd = ofe_pkg::CMD_NONE;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/ofe_engine.sv =====
// back: sector walker, checks, pointer table, seen map and result register
module ofe_engine #(
   parameter int SECTOR_LIMIT  = 1661,
   parameter int TABLE_ENTRIES = 72,
   parameter int MAX_NAME      = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  ofe_pkg::cmd_type                  q_cmd,
   output logic                              q_pop,
   input  logic                              csr_wr_en,
   input  logic [ofe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [63:0]                       csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ofe_pkg::rsp_type                  rsp_payload
);

   localparam int ROWS = (SECTOR_LIMIT + 7) / 8;
   localparam int RW   = $clog2(ROWS);
   localparam int SW   = $clog2(SECTOR_LIMIT);
   localparam int TW   = $clog2(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      PH_IDLE, PH_ROOT, PH_CHAIN, PH_EXT, PH_DATA
   } phase_type;

   typedef enum logic [3:0] {
      E_WAIT, E_VALID, E_HASH, E_MOD, E_CLEAR, E_END,
      E_ND_READ, E_ND_CHECK, E_RQ, E_RQ_CHECK, E_FIN
   } state_type;

   logic [7:0]  seen_mem [ROWS];
   logic [31:0] tbl_mem  [TABLE_ENTRIES];
   logic [7:0]  seen_rd_ff;
   logic [31:0] tbl_rd_ff;

   logic          seen_we, seen_re, tbl_we, tbl_re;
   logic [RW-1:0] seen_waddr, seen_raddr;
   logic [7:0]    seen_wdata;
   logic [TW-1:0] tbl_waddr, tbl_raddr;

   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in, pend_ph_ff, pend_ph_in;
   logic [255:0]    name_ff, name_in;
   logic [19:0]     exp_ff, exp_in, cap_ff, cap_in;
   logic [6:0]      word_ff, word_in;
   logic [31:0]     sum_ff, sum_in;
   logic            ok_ff, ok_in;
   logic [8:0]      bbc_ff, bbc_in;
   logic [19:0]     left_ff, left_in;
   logic [31:0]     seq_ff, seq_in;
   logic [31:0]     ndl_ff, ndl_in, ext_ff, ext_in, chain_ff, chain_in;
   logic [31:0]     pend_ff, pend_in;
   logic [SW-1:0]   hdr_ff, hdr_in, req_sec_ff, req_sec_in;
   logic [10:0]     hash_ff, hash_in;
   logic [4:0]      len_ff, len_in, step_ff, step_in;
   logic [2:0]      modk_ff, modk_in;
   logic [RW-1:0]   clear_ff, clear_in;
   logic [6:0]      pc_ff, pc_in, pp_ff, pp_in;
   logic            nm_ff, nm_in, sm_ff, sm_in;
   logic            stat_ff, stat_in;
   logic            rsp_valid_ff, rsp_valid_in;
   ofe_pkg::rsp_type rsp_ff, rsp_in;

   logic        can_push, push_en, push_last;
   logic [1:0]  push_kind;
   logic [31:0] push_val;
   logic [2:0]  push_vb;
   logic [31:0] x, sum_n;
   logic        ok_n, nm_n, mism;
   logic [7:0]  cur_char, xb;
   logic [8:0]  bpos, nidx;
   logic [14:0] mod_sub;
   logic [6:0]  pp_next;
   logic [2:0]  vb;

   function automatic logic [7:0] name_byte(input logic [255:0] n, input logic [4:0] k);
      return n[{k, 3'b000} +: 8];
   endfunction

   assign can_push    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in   = state_ff;   phase_in = phase_ff;   pend_ph_in = pend_ph_ff;
      name_in    = name_ff;    exp_in   = exp_ff;     cap_in     = cap_ff;
      word_in    = word_ff;    sum_in   = sum_ff;     ok_in      = ok_ff;
      bbc_in     = bbc_ff;     left_in  = left_ff;    seq_in     = seq_ff;
      ndl_in     = ndl_ff;     ext_in   = ext_ff;     chain_in   = chain_ff;
      pend_in    = pend_ff;    hdr_in   = hdr_ff;     req_sec_in = req_sec_ff;
      hash_in    = hash_ff;    len_in   = len_ff;     step_in    = step_ff;
      modk_in    = modk_ff;    clear_in = clear_ff;   pc_in      = pc_ff;
      pp_in      = pp_ff;      nm_in    = nm_ff;      sm_in      = sm_ff;
      stat_in    = stat_ff;
      q_pop      = 1'b0;
      push_en    = 1'b0;  push_last = 1'b1;  push_kind = ofe_pkg::KIND_STATUS;
      push_val   = ofe_pkg::STATUS_FAIL;    push_vb   = 3'd0;
      seen_we    = 1'b0;  seen_re   = 1'b0;  seen_waddr = clear_ff;
      seen_wdata = 8'd0;  seen_raddr = pend_ff[RW+2:3];
      tbl_we     = 1'b0;  tbl_re    = 1'b0;
      tbl_waddr  = TW'(7'(word_ff - 7'd6));
      tbl_raddr  = TW'(TABLE_ENTRIES - 1) - TW'(pp_ff);
      x          = q_cmd.word;
      sum_n      = sum_ff + x;
      ok_n       = ok_ff;
      nm_n       = nm_ff;
      mism       = 1'b0;
      cur_char   = name_byte(name_ff, step_ff);
      xb         = 8'd0;
      bpos       = 9'd0;
      nidx       = 9'd0;
      mod_sub    = 15'(TABLE_ENTRIES) << modk_ff;
      pp_next    = pp_ff + 7'd1;
      vb         = (bbc_ff < 9'd4) ? bbc_ff[2:0] : 3'd4;

      if (csr_wr_en) begin
         unique case (csr_index)
            ofe_pkg::CSR_NAME_A:   name_in[63:0]    = csr_wr_data;
            ofe_pkg::CSR_NAME_B:   name_in[127:64]  = csr_wr_data;
            ofe_pkg::CSR_NAME_C:   name_in[191:128] = csr_wr_data;
            ofe_pkg::CSR_NAME_D:   name_in[255:192] = csr_wr_data;
            ofe_pkg::CSR_EXP_SIZE: exp_in = csr_wr_data[19:0];
            ofe_pkg::CSR_CAPACITY: cap_in = csr_wr_data[19:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         E_WAIT: begin
            if (q_valid && can_push) begin
               q_pop = 1'b1;
               unique case (q_cmd.cmd)
                  ofe_pkg::CMD_START: begin
                     step_in  = 5'd0;
                     state_in = E_VALID;
                  end
                  ofe_pkg::CMD_FAIL: begin
                     if (phase_ff != PH_IDLE) begin
                        push_en  = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  ofe_pkg::CMD_WORD: begin
                     if (phase_ff != PH_IDLE) begin
                        sum_in = sum_n;
                        unique case (phase_ff)
                           PH_ROOT: begin
                              if ((word_ff == 7'd0 && x != ofe_pkg::T_HEADER) ||
                                  (word_ff == 7'd3 && x != 32'(TABLE_ENTRIES)) ||
                                  (word_ff == 7'd127 && x != ofe_pkg::ST_ROOT)) begin
                                 ok_n = 1'b0;
                              end
                              if ({1'b0, word_ff} == 8'(hash_ff) + 8'd6) begin
                                 chain_in = x;
                              end
                           end
                           PH_CHAIN, PH_EXT: begin
                              if (word_ff >= 7'd6 && {1'b0, word_ff} < 8'(TABLE_ENTRIES + 6)) begin
                                 tbl_we = 1'b1;
                              end
                              if (word_ff == 7'd0 && x != ((phase_ff == PH_CHAIN) ?
                                  ofe_pkg::T_HEADER : ofe_pkg::T_LIST)) begin
                                 ok_n = 1'b0;
                              end
                              if (word_ff == 7'd1 && x != 32'(req_sec_ff)) begin
                                 ok_n = 1'b0;
                              end
                              if (word_ff == 7'd2) begin
                                 if (x > 32'(TABLE_ENTRIES)) begin
                                    ok_n = 1'b0;
                                 end else begin
                                    pc_in = x[6:0];
                                 end
                              end
                              if (word_ff == 7'd125 && x != ((phase_ff == PH_CHAIN) ?
                                  ofe_pkg::ROOT_SECTOR : 32'(hdr_ff))) begin
                                 ok_n = 1'b0;
                              end
                              if (word_ff == 7'd126) begin
                                 ext_in = x;
                              end
                              if (word_ff == 7'd127 && x != ofe_pkg::ST_FILE) begin
                                 ok_n = 1'b0;
                              end
                              if (phase_ff == PH_CHAIN) begin
                                 if (word_ff == 7'd4) begin
                                    ndl_in = x;
                                 end
                                 if (word_ff == 7'd81) begin
                                    sm_in = (x == 32'(exp_ff));
                                 end
                                 if (word_ff == 7'd124) begin
                                    chain_in = x;
                                 end
                                 if (word_ff == 7'd108) begin
                                    if (x[31:24] == 8'd0 || x[31:24] > 8'(MAX_NAME)) begin
                                       ok_n = 1'b0;
                                    end
                                    nm_n = (x[31:24] == 8'(len_ff));
                                 end
                                 if (word_ff >= 7'd108 && word_ff <= 7'd115) begin
                                    for (int j = 0; j < 4; j++) begin
                                       bpos = {word_ff, 2'b00} + 9'(j);
                                       nidx = bpos - 9'd433;
                                       xb   = x[(3 - j) * 8 +: 8];
                                       if (bpos >= 9'd433 && nidx < 9'(len_ff) &&
                                           ofe_pkg::upcase(xb) !=
                                           ofe_pkg::upcase(name_byte(name_ff, nidx[4:0]))) begin
                                          mism = 1'b1;
                                       end
                                    end
                                 end
                                 nm_in = nm_n && !mism;
                              end
                           end
                           PH_DATA: begin
                              if ((word_ff == 7'd0 && x != ofe_pkg::T_DATA) ||
                                  (word_ff == 7'd1 && x != 32'(hdr_ff)) ||
                                  (word_ff == 7'd2 && x != seq_ff)) begin
                                 ok_n = 1'b0;
                              end
                              if (word_ff == 7'd3) begin
                                 if (x == 32'd0 || x > ofe_pkg::DATA_MAX || x > 32'(left_ff)) begin
                                    ok_n   = 1'b0;
                                    bbc_in = 9'd0;
                                 end else begin
                                    bbc_in = x[8:0];
                                 end
                              end
                              if (word_ff == 7'd4) begin
                                 ndl_in = x;
                                 if (ok_ff) begin
                                    if (20'(bbc_ff) == left_ff && (x != 32'd0 || ext_ff != 32'd0 ||
                                        {1'b0, pp_ff} + 8'd1 != {1'b0, pc_ff})) begin
                                       ok_n = 1'b0;
                                    end else begin
                                       left_in = left_ff - 20'(bbc_ff);
                                    end
                                 end
                              end
                              if (word_ff >= 7'd6 && ok_ff && bbc_ff != 9'd0) begin
                                 push_en   = 1'b1;
                                 push_kind = ofe_pkg::KIND_PAYLOAD;
                                 push_val  = x;
                                 push_vb   = vb;
                                 push_last = (word_ff != 7'd127);
                                 bbc_in    = bbc_ff - 9'(vb);
                              end
                           end
                           default: ;
                        endcase
                        ok_in   = ok_n;
                        word_in = word_ff + 7'd1;
                        if (word_ff == 7'd127) begin
                           ok_in    = ok_n && (sum_n == 32'd0);
                           state_in = E_END;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         E_VALID: begin
            if (cur_char == 8'd0) begin
               len_in = step_ff;
               if (step_ff == 5'd0 || exp_ff == 20'd0 || exp_ff > cap_ff) begin
                  stat_in  = 1'b0;
                  state_in = E_FIN;
               end else begin
                  hash_in  = 11'(step_ff);
                  step_in  = 5'd0;
                  left_in  = exp_ff;
                  seq_in   = 32'd1;
                  ndl_in   = 32'd0;
                  ext_in   = 32'd0;
                  hdr_in   = '0;
                  chain_in = 32'd0;
                  pc_in    = 7'd0;
                  pp_in    = 7'd0;
                  bbc_in   = 9'd0;
                  state_in = E_HASH;
               end
            end else if (step_ff == 5'(MAX_NAME) || cur_char < ofe_pkg::CHAR_LOW ||
                         cur_char > ofe_pkg::CHAR_HIGH || cur_char == ofe_pkg::CHAR_COLON ||
                         cur_char == ofe_pkg::CHAR_SLASH) begin
               stat_in  = 1'b0;
               state_in = E_FIN;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         E_HASH: begin
            hash_in = hash_ff * ofe_pkg::HASH_MULT + 11'(ofe_pkg::upcase(cur_char));
            step_in = step_ff + 5'd1;
            if (step_ff == len_ff - 5'd1) begin
               modk_in  = 3'd7;
               state_in = E_MOD;
            end
         end
         E_MOD: begin
            if (15'(hash_ff) >= mod_sub) begin
               hash_in = hash_ff - 11'(mod_sub);
            end
            modk_in = modk_ff - 3'd1;
            if (modk_ff == 3'd0) begin
               clear_in = '0;
               state_in = E_CLEAR;
            end
         end
         E_CLEAR: begin
            seen_we  = 1'b1;
            clear_in = clear_ff + RW'(1);
            if (clear_ff == RW'(ROWS - 1)) begin
               pend_in    = ofe_pkg::ROOT_SECTOR;
               pend_ph_in = PH_ROOT;
               state_in   = E_RQ;
            end
         end
         E_END: begin
            stat_in = 1'b0;
            if (!ok_ff) begin
               state_in = E_FIN;
            end else begin
               unique case (phase_ff)
                  PH_ROOT: begin
                     pend_in    = chain_ff;
                     pend_ph_in = PH_CHAIN;
                     state_in   = E_RQ;
                  end
                  PH_CHAIN: begin
                     if (!nm_ff) begin
                        pend_in    = chain_ff;
                        pend_ph_in = PH_CHAIN;
                        state_in   = E_RQ;
                     end else if (!sm_ff || pc_ff == 7'd0) begin
                        state_in = E_FIN;
                     end else begin
                        hdr_in   = req_sec_ff;
                        pp_in    = 7'd0;
                        state_in = E_ND_READ;
                     end
                  end
                  PH_EXT: begin
                     if (pc_ff == 7'd0) begin
                        state_in = E_FIN;
                     end else begin
                        pp_in    = 7'd0;
                        state_in = E_ND_READ;
                     end
                  end
                  default: begin
                     seq_in = seq_ff + 32'd1;
                     pp_in  = pp_next;
                     if (pp_next < pc_ff) begin
                        state_in = E_ND_READ;
                     end else if (left_ff == 20'd0) begin
                        stat_in  = (ext_ff == 32'd0 && ndl_ff == 32'd0);
                        state_in = E_FIN;
                     end else begin
                        pend_in    = ext_ff;
                        pend_ph_in = PH_EXT;
                        state_in   = E_RQ;
                     end
                  end
               endcase
            end
         end
         E_ND_READ: begin
            if (left_ff == 20'd0 || {1'b0, pp_ff} >= 8'(TABLE_ENTRIES)) begin
               stat_in  = 1'b0;
               state_in = E_FIN;
            end else begin
               tbl_re   = 1'b1;
               state_in = E_ND_CHECK;
            end
         end
         E_ND_CHECK: begin
            if (tbl_rd_ff != ndl_ff) begin
               stat_in  = 1'b0;
               state_in = E_FIN;
            end else begin
               pend_in    = tbl_rd_ff;
               pend_ph_in = PH_DATA;
               state_in   = E_RQ;
            end
         end
         E_RQ: begin
            if (pend_ff < 32'd2 || pend_ff >= 32'(SECTOR_LIMIT)) begin
               stat_in  = 1'b0;
               state_in = E_FIN;
            end else begin
               seen_re  = 1'b1;
               state_in = E_RQ_CHECK;
            end
         end
         E_RQ_CHECK: begin
            if (seen_rd_ff[pend_ff[2:0]]) begin
               stat_in  = 1'b0;
               state_in = E_FIN;
            end else if (can_push) begin
               seen_we    = 1'b1;
               seen_waddr = pend_ff[RW+2:3];
               seen_wdata = seen_rd_ff | (8'd1 << pend_ff[2:0]);
               req_sec_in = pend_ff[SW-1:0];
               phase_in   = pend_ph_ff;
               word_in    = 7'd0;
               sum_in     = 32'd0;
               ok_in      = 1'b1;
               push_en    = 1'b1;
               push_kind  = ofe_pkg::KIND_REQUEST;
               push_val   = pend_ff;
               state_in   = E_WAIT;
            end
         end
         E_FIN: begin
            if (can_push) begin
               push_en  = 1'b1;
               push_val = stat_ff ? ofe_pkg::STATUS_OK : ofe_pkg::STATUS_FAIL;
               phase_in = PH_IDLE;
               state_in = E_WAIT;
            end
         end
         default: state_in = E_WAIT;
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (push_en) begin
         rsp_valid_in       = 1'b1;
         rsp_in.kind        = push_kind;
         rsp_in.value       = push_val;
         rsp_in.valid_bytes = push_vb;
         rsp_in.block_last  = push_last;
      end
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      if (seen_re) begin
         seen_rd_ff <= seen_mem[seen_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= x;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff   <= E_WAIT;     phase_ff <= PH_IDLE;  pend_ph_ff <= PH_IDLE;
         name_ff    <= '0;         exp_ff   <= '0;       cap_ff     <= '0;
         word_ff    <= '0;         sum_ff   <= '0;       ok_ff      <= 1'b1;
         bbc_ff     <= '0;         left_ff  <= '0;       seq_ff     <= 32'd1;
         ndl_ff     <= '0;         ext_ff   <= '0;       chain_ff   <= '0;
         pend_ff    <= '0;         hdr_ff   <= '0;       req_sec_ff <= '0;
         hash_ff    <= '0;         len_ff   <= '0;       step_ff    <= '0;
         modk_ff    <= '0;         clear_ff <= '0;       pc_ff      <= '0;
         pp_ff      <= '0;         nm_ff    <= 1'b0;     sm_ff      <= 1'b0;
         stat_ff    <= 1'b0;       rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;   phase_ff <= phase_in; pend_ph_ff <= pend_ph_in;
         name_ff    <= name_in;    exp_ff   <= exp_in;   cap_ff     <= cap_in;
         word_ff    <= word_in;    sum_ff   <= sum_in;   ok_ff      <= ok_in;
         bbc_ff     <= bbc_in;     left_ff  <= left_in;  seq_ff     <= seq_in;
         ndl_ff     <= ndl_in;     ext_ff   <= ext_in;   chain_ff   <= chain_in;
         pend_ff    <= pend_in;    hdr_ff   <= hdr_in;   req_sec_ff <= req_sec_in;
         hash_ff    <= hash_in;    len_ff   <= len_in;   step_ff    <= step_in;
         modk_ff    <= modk_in;    clear_ff <= clear_in; pc_ff      <= pc_in;
         pp_ff      <= pp_in;      nm_ff    <= nm_in;    sm_ff      <= sm_in;
         stat_ff    <= stat_in;    rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/ofs_file_extractor_core.sv =====
// top level of the ofs file extractor: input queue, sector engine, result register
// the engine checks each sector word as it pops it; at the end of a sector it may read the
// pointer table, then reads and updates the seen map (single-port memories)
// start scans the name, hashes it, reduces the hash to its remainder and clears the seen map
// row by row ((SECTOR_LIMIT+7)/8 rows, 208 by default)
// synchronous active-high reset empties the queue, idles the engine, zeroes most engine registers
module ofs_file_extractor_core #(
   parameter int SECTOR_LIMIT  = 1661,
   parameter int TABLE_ENTRIES = 72,
   parameter int MAX_NAME      = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ofe_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ofe_pkg::rsp_type                rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [ofe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_wr_data
);

   logic             q_valid;
   logic             q_pop;
   ofe_pkg::cmd_type q_cmd;

   ofe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop)
   );

   ofe_engine #(
      .SECTOR_LIMIT  (SECTOR_LIMIT),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_NAME      (MAX_NAME)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/ofs_file_extractor_core_tb.sv =====
// testbench for the ofs file extractor core: random disk image loads checked by a predictor
module ofs_file_extractor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECTOR_LIMIT  = 1661;
   localparam int TABLE_ENTRIES = 72;
   localparam int MAX_NAME      = 30;
   localparam int SETTLE        = 320;
   localparam int TARGET_ITEMS  = 1150;
   localparam logic [1:0] OPC_NONE = 2'd3;

   typedef enum {LD_IDLE, LD_ROOT, LD_CHAIN, LD_EXT, LD_DATA} load_phase_type;
   typedef logic [127:0][31:0] sector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ofe_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ofe_pkg::rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [ofe_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0] csr_wr_data = '0;

   ofs_file_extractor_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // predictor state
   logic [63:0] name_reg [4];
   logic [19:0] want_size, cap_size;
   load_phase_type ld_phase;
   logic [6:0]  wix, pcount, ppos;
   logic [31:0] csum, seq_no, data_link, ext_link, hdr_sec, req_sec, chain_sec;
   bit          seen_sec [SECTOR_LIMIT];
   logic [31:0] ptab [TABLE_ENTRIES];
   logic [19:0] left_bytes;
   logic [10:0] nhash;
   logic [4:0]  nlen;
   logic [8:0]  blk_bytes;
   bit          blk_ok, name_ok, size_ok;

   ofe_pkg::rsp_type due_results [$];
   ofe_pkg::req_type pend [$];
   int errors = 0, live_items = 0, sent_items = 0, loads = 0, ok_loads = 0;
   int payload_words = 0, sector_reqs = 0;

   function automatic logic [7:0] fold(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] name_chr(int k);
      return name_reg[k / 8][(k % 8) * 8 +: 8];
   endfunction

   function automatic void emit(logic [1:0] k, logic [31:0] v, logic [2:0] vb);
      ofe_pkg::rsp_type r;
      r.kind = k; r.value = v; r.valid_bytes = vb; r.block_last = 1'b0;
      due_results.push_back(r);
   endfunction

   function automatic void close_load(logic [31:0] st);
      emit(ofe_pkg::KIND_STATUS, st, 3'd0);
      ld_phase = LD_IDLE;
   endfunction

   function automatic void ask_sector(logic [31:0] s, load_phase_type ph);
      if (s < 2 || s >= SECTOR_LIMIT || seen_sec[s]) begin
         close_load(ofe_pkg::STATUS_FAIL);
         return;
      end
      seen_sec[s] = 1'b1;
      req_sec = s; ld_phase = ph; wix = '0; csum = '0; blk_ok = 1'b1;
      emit(ofe_pkg::KIND_REQUEST, s, 3'd0);
   endfunction

   function automatic void next_data_block();
      logic [31:0] ds;
      if (left_bytes == 0 || ppos >= TABLE_ENTRIES) begin
         close_load(ofe_pkg::STATUS_FAIL);
         return;
      end
      ds = ptab[TABLE_ENTRIES - 1 - int'(ppos)];
      if (ds != data_link) close_load(ofe_pkg::STATUS_FAIL);
      else ask_sector(ds, LD_DATA);
   endfunction

   function automatic void start_load();
      int len, hh;
      bit bad, stop;
      logic [7:0] c;
      len = 0; bad = 1'b0; stop = 1'b0;
      for (int k = 0; k < 32 && !stop; k++) begin
         c = name_chr(k);
         if (c == 0) stop = 1'b1;
         else if (k == MAX_NAME || c < ofe_pkg::CHAR_LOW || c > ofe_pkg::CHAR_HIGH ||
                  c == ofe_pkg::CHAR_COLON || c == ofe_pkg::CHAR_SLASH) begin
            bad = 1'b1; stop = 1'b1;
         end else len++;
      end
      if (bad || len == 0 || want_size == 0 || want_size > cap_size) begin
         close_load(ofe_pkg::STATUS_FAIL);
         return;
      end
      hh = len;
      for (int k = 0; k < len; k++) hh = (hh * 13 + int'(fold(name_chr(k)))) & 'h7ff;
      nhash = hh[10:0]; nlen = len[4:0];
      foreach (seen_sec[i]) seen_sec[i] = 1'b0;
      left_bytes = want_size; seq_no = 32'd1;
      data_link = '0; ext_link = '0; hdr_sec = '0; chain_sec = '0;
      pcount = '0; ppos = '0; blk_bytes = '0;
      ask_sector(ofe_pkg::ROOT_SECTOR, LD_ROOT);
   endfunction

   function automatic void take_word(logic [31:0] x);
      int w, b;
      bit hdr;
      logic [2:0] vb;
      w = int'(wix);
      csum = csum + x;
      if (ld_phase == LD_ROOT) begin
         if ((w == 0 && x != ofe_pkg::T_HEADER) || (w == 3 && x != TABLE_ENTRIES) ||
             (w == 127 && x != ofe_pkg::ST_ROOT)) blk_ok = 1'b0;
         if (w == 6 + int'(nhash) % TABLE_ENTRIES) chain_sec = x;
      end else if (ld_phase == LD_CHAIN || ld_phase == LD_EXT) begin
         hdr = (ld_phase == LD_CHAIN);
         if (w >= 6 && w < 6 + TABLE_ENTRIES) ptab[w - 6] = x;
         if (w == 0 && x != (hdr ? ofe_pkg::T_HEADER : ofe_pkg::T_LIST)) blk_ok = 1'b0;
         if (w == 1 && x != req_sec) blk_ok = 1'b0;
         if (w == 2) begin
            if (x > TABLE_ENTRIES) blk_ok = 1'b0;
            else pcount = x[6:0];
         end
         if (w == 125 && x != (hdr ? ofe_pkg::ROOT_SECTOR : hdr_sec)) blk_ok = 1'b0;
         if (w == 126) ext_link = x;
         if (w == 127 && x != ofe_pkg::ST_FILE) blk_ok = 1'b0;
         if (hdr) begin
            if (w == 4) data_link = x;
            if (w == 81) size_ok = (x == {12'd0, want_size});
            if (w == 124) chain_sec = x;
            if (w == 108) begin
               if (x[31:24] == 0 || x[31:24] > MAX_NAME) blk_ok = 1'b0;
               name_ok = (x[31:24] == {3'd0, nlen});
            end
            if (w >= 108 && w <= 115) begin
               for (int j = 0; j < 4; j++) begin
                  b = 4 * w + j;
                  if (b >= 433 && b - 433 < int'(nlen) &&
                      fold(x[(3 - j) * 8 +: 8]) != fold(name_chr(b - 433))) name_ok = 1'b0;
               end
            end
         end
      end else begin
         if ((w == 0 && x != ofe_pkg::T_DATA) || (w == 1 && x != hdr_sec) ||
             (w == 2 && x != seq_no)) blk_ok = 1'b0;
         if (w == 3) begin
            if (x == 0 || x > ofe_pkg::DATA_MAX || x > {12'd0, left_bytes}) begin
               blk_ok = 1'b0; blk_bytes = '0;
            end else blk_bytes = x[8:0];
         end
         if (w == 4) begin
            data_link = x;
            if (blk_ok) begin
               if ({11'd0, blk_bytes} == left_bytes &&
                   (x != 0 || ext_link != 0 || int'(ppos) + 1 != int'(pcount))) blk_ok = 1'b0;
               else left_bytes = left_bytes - {11'd0, blk_bytes};
            end
         end
         if (w >= 6 && blk_ok && blk_bytes > 0) begin
            vb = (blk_bytes < 4) ? blk_bytes[2:0] : 3'd4;
            emit(ofe_pkg::KIND_PAYLOAD, x, vb);
            blk_bytes = blk_bytes - {6'd0, vb};
         end
      end
      wix = wix + 7'd1;
      if (w != 127) return;
      if (csum != 0) blk_ok = 1'b0;
      if (!blk_ok) begin
         close_load(ofe_pkg::STATUS_FAIL);
         return;
      end
      case (ld_phase)
         LD_ROOT: ask_sector(chain_sec, LD_CHAIN);
         LD_CHAIN: begin
            if (!name_ok) ask_sector(chain_sec, LD_CHAIN);
            else if (!size_ok || pcount == 0) close_load(ofe_pkg::STATUS_FAIL);
            else begin
               hdr_sec = req_sec; ppos = '0;
               next_data_block();
            end
         end
         LD_EXT: begin
            if (pcount == 0) close_load(ofe_pkg::STATUS_FAIL);
            else begin
               ppos = '0;
               next_data_block();
            end
         end
         default: begin
            seq_no = seq_no + 32'd1;
            ppos = ppos + 7'd1;
            if (ppos < pcount) next_data_block();
            else if (left_bytes == 0)
               close_load((ext_link == 0 && data_link == 0) ?
                          ofe_pkg::STATUS_OK : ofe_pkg::STATUS_FAIL);
            else ask_sector(ext_link, LD_EXT);
         end
      endcase
   endfunction

   function automatic void extract_step(ofe_pkg::req_type r);
      int n0;
      ofe_pkg::rsp_type t;
      n0 = due_results.size();
      if (r.opcode == ofe_pkg::OPC_START) begin
         live_items++; loads++;
         start_load();
      end else if (r.opcode == ofe_pkg::OPC_WORD && ld_phase != LD_IDLE) begin
         live_items++;
         take_word(r.sector_word);
      end else if (r.opcode == ofe_pkg::OPC_FAIL && ld_phase != LD_IDLE) begin
         live_items++;
         close_load(ofe_pkg::STATUS_FAIL);
      end
      if (due_results.size() > n0) begin
         t = due_results.pop_back();
         t.block_last = 1'b1;
         due_results.push_back(t);
      end
   endfunction

   // sender
   int gap_left = 0, burst_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            extract_step(req_payload);
            pend.delete(0);
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (pend.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= pend[0];
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 60);
               gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            end else burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver and checker
   int stall_mode = 0, stall_left = 0;
   always @(posedge clock) begin
      ofe_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer kind=%0d value=%h bytes=%0d last=%0b",
                        $time, rsp_payload.kind, rsp_payload.value,
                        rsp_payload.valid_bytes, rsp_payload.block_last);
            end else begin
               want = due_results.pop_front();
               if (rsp_payload !== want) begin
                  errors++;
                  $display("%0t: mismatch expected kind=%0d value=%h bytes=%0d last=%0b,",
                           $time, want.kind, want.value, want.valid_bytes,
                           want.block_last);
                  $display("   got kind=%0d value=%h bytes=%0d last=%0b",
                           rsp_payload.kind, rsp_payload.value,
                           rsp_payload.valid_bytes, rsp_payload.block_last);
               end
               if (want.kind == ofe_pkg::KIND_STATUS && want.value == ofe_pkg::STATUS_OK)
                  ok_loads++;
               if (want.kind == ofe_pkg::KIND_PAYLOAD) payload_words++;
               if (want.kind == ofe_pkg::KIND_REQUEST) sector_reqs++;
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
         end else stall_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom % 4 == 0);
            2: rsp_stall <= ($urandom % 4 != 0);
            default: rsp_stall <= 1'b1;
         endcase
      end
   end

   // disk image generation
   sector_type  plan [$];
   bit          used [SECTOR_LIMIT];
   logic [7:0]  fname [MAX_NAME];
   int          flen;
   logic [19:0] fsize;

   function automatic void push_item(logic [1:0] op, logic [31:0] w);
      ofe_pkg::req_type r;
      r.opcode = op; r.sector_word = w;
      pend.push_back(r);
      sent_items++;
   endfunction

   function automatic logic [7:0] rand_char();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 126));
      while (c == ofe_pkg::CHAR_COLON || c == ofe_pkg::CHAR_SLASH);
      return c;
   endfunction

   function automatic int fresh_sector();
      int s;
      do s = $urandom_range(2, SECTOR_LIMIT - 1);
      while (used[s] || s == ofe_pkg::ROOT_SECTOR);
      used[s] = 1'b1;
      return s;
   endfunction

   function automatic sector_type seal(sector_type s);
      logic [31:0] sum;
      s[5] = '0; sum = '0;
      for (int i = 0; i < 128; i++) sum = sum + s[i];
      s[5] = -sum;
      return s;
   endfunction

   function automatic sector_type rand_sector();
      sector_type s;
      for (int i = 0; i < 128; i++) s[i] = $urandom;
      return s;
   endfunction

   function automatic sector_type put_name_byte(sector_type s, int b, logic [7:0] v);
      s[b / 4][(3 - b % 4) * 8 +: 8] = v;
      return s;
   endfunction

   function automatic void build_image();
      int nfake, hh, idx, cnt, rem, bsz, slot;
      int chain [$], ds [$], nbytes [$], gstart [$], gcnt [$], ext [$];
      sector_type s;
      logic [7:0] c;
      plan.delete();
      foreach (used[i]) used[i] = 1'b0;
      nfake = ($urandom % 5 == 0) ? $urandom_range(1, 2) : 0;
      for (int i = 0; i <= nfake; i++) chain.push_back(fresh_sector());
      rem = int'(fsize);
      while (rem > 0) begin
         bsz = (rem <= int'(ofe_pkg::DATA_MAX)) ? rem : $urandom_range(200, 488);
         ds.push_back(fresh_sector());
         nbytes.push_back(bsz);
         rem -= bsz;
      end
      idx = 0;
      while (idx < ds.size()) begin
         cnt = $urandom_range(1, 3);
         if (cnt > ds.size() - idx) cnt = ds.size() - idx;
         if (gstart.size() > 0) ext.push_back(fresh_sector());
         gstart.push_back(idx); gcnt.push_back(cnt);
         idx += cnt;
      end
      hh = flen;
      for (int k = 0; k < flen; k++) hh = (hh * 13 + int'(fold(fname[k]))) & 'h7ff;
      slot = 6 + hh % TABLE_ENTRIES;
      s = rand_sector();
      s[0] = ofe_pkg::T_HEADER; s[3] = TABLE_ENTRIES; s[127] = ofe_pkg::ST_ROOT;
      s[slot] = chain[0];
      plan.push_back(seal(s));
      foreach (chain[i]) begin
         s = rand_sector();
         s[0] = ofe_pkg::T_HEADER; s[1] = chain[i]; s[125] = ofe_pkg::ROOT_SECTOR;
         s[127] = ofe_pkg::ST_FILE;
         if (i < nfake) begin
            s[2] = $urandom_range(0, TABLE_ENTRIES);
            s[124] = chain[i + 1];
            s = put_name_byte(s, 432, 8'((flen % MAX_NAME) + 1));
            for (int k = 0; k < (flen % MAX_NAME) + 1; k++)
               s = put_name_byte(s, 433 + k, rand_char());
         end else begin
            s[2] = gcnt[0]; s[4] = ds[0]; s[81] = {12'd0, fsize}; s[124] = '0;
            s[126] = (ext.size() > 0) ? ext[0] : 0;
            for (int p = 0; p < gcnt[0]; p++) s[6 + TABLE_ENTRIES - 1 - p] = ds[p];
            s = put_name_byte(s, 432, 8'(flen));
            for (int k = 0; k < flen; k++) begin
               c = fname[k];
               if ($urandom % 2 && c >= "A" && c <= "Z") c = c + 8'd32;
               if ($urandom % 2) c = fold(c);
               s = put_name_byte(s, 433 + k, c);
            end
         end
         plan.push_back(seal(s));
      end
      foreach (gstart[g]) begin
         if (g > 0) begin
            s = rand_sector();
            s[0] = ofe_pkg::T_LIST; s[1] = ext[g - 1]; s[2] = gcnt[g];
            s[125] = chain[nfake];
            s[126] = (g < ext.size()) ? ext[g] : 0; s[127] = ofe_pkg::ST_FILE;
            for (int p = 0; p < gcnt[g]; p++)
               s[6 + TABLE_ENTRIES - 1 - p] = ds[gstart[g] + p];
            plan.push_back(seal(s));
         end
         for (int i = gstart[g]; i < gstart[g] + gcnt[g]; i++) begin
            s = rand_sector();
            s[0] = ofe_pkg::T_DATA; s[1] = chain[nfake]; s[2] = i + 1; s[3] = nbytes[i];
            s[4] = (i + 1 < ds.size()) ? ds[i + 1] : 0;
            plan.push_back(seal(s));
         end
      end
   endfunction

   function automatic void corrupt_image();
      int si, w;
      int picks [11] = '{0, 1, 2, 3, 4, 81, 108, 124, 125, 126, 127};
      si = $urandom_range(0, plan.size() - 1);
      w = ($urandom % 2) ? picks[$urandom_range(0, 10)] : $urandom_range(0, 127);
      case ($urandom_range(0, 5))
         0: plan[si][w] = $urandom_range(0, 1);
         1: plan[si][w] = ofe_pkg::ROOT_SECTOR;
         2: plan[si][w] = $urandom_range(SECTOR_LIMIT, SECTOR_LIMIT + 3);
         3: plan[si][w] = $urandom;
         4: plan[si][w] = plan[si][w] ^ (32'd1 << $urandom_range(0, 31));
         default: plan[si][w] = plan[si][w] + 32'd1;
      endcase
      if ($urandom % 4 != 0) plan[si] = seal(plan[si]);
   endfunction

   function automatic void send_image(int cut, bit restart);
      int n;
      n = 0;
      foreach (plan[i]) begin
         for (int w = 0; w < 128; w++) begin
            if (n == cut) begin
               if (restart) begin
                  push_item(ofe_pkg::OPC_START, $urandom);
                  send_image(-1, 1'b0);
               end else push_item(ofe_pkg::OPC_FAIL, $urandom);
               return;
            end
            if ($urandom % 97 == 0) push_item(OPC_NONE, $urandom);
            push_item(ofe_pkg::OPC_WORD, plan[i][w]);
            n++;
         end
      end
   endfunction

   task automatic settle();
      while (pend.size() != 0 || due_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [ofe_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] d);
      @(posedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wr_data <= d;
      case (idx)
         ofe_pkg::CSR_NAME_A: name_reg[0] = d;
         ofe_pkg::CSR_NAME_B: name_reg[1] = d;
         ofe_pkg::CSR_NAME_C: name_reg[2] = d;
         ofe_pkg::CSR_NAME_D: name_reg[3] = d;
         ofe_pkg::CSR_EXP_SIZE: want_size = d[19:0];
         ofe_pkg::CSR_CAPACITY: cap_size = d[19:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_load(logic [63:0] a, logic [63:0] b, logic [63:0] c, logic [63:0] d,
                           logic [19:0] sz, logic [19:0] cap);
      settle();
      csr_write(ofe_pkg::CSR_NAME_A, a);
      csr_write(ofe_pkg::CSR_NAME_B, b);
      csr_write(ofe_pkg::CSR_NAME_C, c);
      csr_write(ofe_pkg::CSR_NAME_D, d);
      csr_write(ofe_pkg::CSR_EXP_SIZE, {44'd0, sz});
      csr_write(ofe_pkg::CSR_CAPACITY, {44'd0, cap});
      @(negedge clock);
   endtask

   task automatic random_config();
      logic [63:0] r [4];
      logic [19:0] cap;
      r = '{default: '0};
      flen = $urandom_range(1, MAX_NAME);
      for (int i = 0; i < flen; i++) begin
         fname[i] = rand_char();
         r[i / 8][(i % 8) * 8 +: 8] = fname[i];
      end
      fsize = ($urandom % 8 == 0) ? 20'($urandom_range(489, 1100)) :
                                     20'($urandom_range(1, 488));
      cap = ($urandom % 4 != 0) ? 20'($urandom_range(int'(fsize), 20'hfffff)) : fsize;
      set_load(r[0], r[1], r[2], r[3], fsize, cap);
   endtask

   initial begin
      int cut, room;
      bit restart;
      foreach (ptab[i]) ptab[i] = '0;
      foreach (seen_sec[i]) seen_sec[i] = 1'b0;
      name_reg = '{default: '0};
      want_size = '0; cap_size = '0; ld_phase = LD_IDLE;
      wix = '0; csum = '0; pcount = '0; ppos = '0; left_bytes = '0; seq_no = 32'd1;
      data_link = '0; ext_link = '0; hdr_sec = '0; req_sec = '0; chain_sec = '0;
      nhash = '0; nlen = '0; blk_ok = 1'b1; blk_bytes = '0; name_ok = 1'b0;
      size_ok = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle commands are ignored, empty name is rejected
      push_item(ofe_pkg::OPC_WORD, 32'hffffffff);
      push_item(ofe_pkg::OPC_FAIL, 32'h0);
      push_item(OPC_NONE, 32'h5a5a5a5a);
      push_item(ofe_pkg::OPC_START, 32'h0);
      // name longer than the limit
      set_load({8{8'h7a}}, {8{8'h7a}}, {8{8'h7a}}, 64'h0041_7a7a_7a7a_7a7a, 20'd1, 20'd1);
      push_item(ofe_pkg::OPC_START, 32'h0);
      // longest name, largest size, restart while busy, read failure
      set_load({8{8'h7e}}, {8{8'h61}}, {8{8'h20}}, 64'h0000_5a41_7e20_7a61, 20'hfffff,
               20'hfffff);
      push_item(ofe_pkg::OPC_START, 32'h0);
      push_item(ofe_pkg::OPC_START, 32'hffffffff);
      push_item(ofe_pkg::OPC_FAIL, 32'h0);
      // illegal characters
      set_load(64'h41_3a, 64'h0, 64'h0, 64'h0, 20'd4, 20'd8);
      push_item(ofe_pkg::OPC_START, 32'h0);
      set_load(64'h2f, 64'h0, 64'h0, 64'h0, 20'd4, 20'd8);
      push_item(ofe_pkg::OPC_START, 32'h0);
      set_load(64'h1f, 64'h0, 64'h0, 64'h0, 20'd4, 20'd8);
      push_item(ofe_pkg::OPC_START, 32'h0);
      set_load(64'h7f_41, 64'h0, 64'h0, 64'h0, 20'd4, 20'd8);
      push_item(ofe_pkg::OPC_START, 32'h0);
      set_load(64'hffff_ffff_ffff_ffff, 64'h0, 64'h0, 64'h0, 20'd4, 20'd8);
      push_item(ofe_pkg::OPC_START, 32'h0);
      // size zero, size above capacity
      set_load(64'h41, 64'h0, 64'h0, 64'h0, 20'd0, 20'hfffff);
      push_item(ofe_pkg::OPC_START, 32'h0);
      set_load(64'h41, 64'h0, 64'h0, 64'h0, 20'd2, 20'd1);
      push_item(ofe_pkg::OPC_START, 32'h0);
      // failure in the middle of the root sector with ignored noise
      set_load(64'h6d, 64'h0, 64'h0, 64'h0, 20'd1, 20'hfffff);
      push_item(ofe_pkg::OPC_START, 32'h0);
      push_item(ofe_pkg::OPC_WORD, ofe_pkg::T_HEADER);
      push_item(OPC_NONE, 32'h0);
      push_item(ofe_pkg::OPC_FAIL, 32'hffffffff);

      for (bit first = 1'b1; sent_items < TARGET_ITEMS; first = 1'b0) begin
         if (first || $urandom % 2) random_config();
         while (pend.size() > 256) @(negedge clock);
         build_image();
         if ($urandom % 5 < 2) corrupt_image();
         push_item(ofe_pkg::OPC_START, $urandom);
         cut = -1;
         restart = 1'($urandom_range(0, 1));
         if ($urandom % 6 == 0) cut = $urandom_range(0, plan.size() * 128 - 1);
         room = TARGET_ITEMS - sent_items;
         if (room < 0) room = 0;
         if (plan.size() * 128 > room && (cut < 0 || cut > room || restart)) begin
            cut = room;
            restart = 1'b0;
         end
         send_image(cut, restart);
         if ($urandom % 4 == 0) begin
            push_item(ofe_pkg::OPC_WORD, $urandom);
            push_item(ofe_pkg::OPC_FAIL, $urandom);
         end
      end

      settle();
      $display("run covered %0d sent items (%0d acted on), %0d loads, %0d completed",
               sent_items, live_items, loads, ok_loads);
      $display("and %0d sector requests, %0d payload words", sector_reqs, payload_words);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/ofe_pkg.sv
sv/ofe_front.sv
sv/ofe_engine.sv
sv/ofs_file_extractor_core.sv
tb/ofs_file_extractor_core_tb.sv
